// ===== rtl/core/stc_pkg.sv =====
// shared types, constants and byte classification for the source text tokenizer
`default_nettype none

package stc_pkg;

  localparam int STC_OFFSET_BITS = 20;
  localparam int STC_LINE_BITS   = 16;
  localparam int STC_QUEUE_DEPTH = 4;
  localparam int STC_MAX_TOKENS  = 3;
  localparam int STC_PREFIX_BITS = 48;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_NUM   = 2'd2
  } scan_mode_t;

  typedef enum logic [3:0] {
    KIND_EOF    = 4'd0,
    KIND_IDENT  = 4'd1,
    KIND_INT    = 4'd2,
    KIND_VAR    = 4'd3,
    KIND_FUNC   = 4'd4,
    KIND_RETURN = 4'd5,
    KIND_PLUS   = 4'd6,
    KIND_EQUAL  = 4'd7,
    KIND_SEMI   = 4'd8,
    KIND_COLON  = 4'd9,
    KIND_LPAREN = 4'd10,
    KIND_RPAREN = 4'd11,
    KIND_LBRACE = 4'd12,
    KIND_RBRACE = 4'd13
  } tok_kind_t;

  // keyword spellings, first byte in the low bits
  localparam logic [STC_PREFIX_BITS-1:0] KW_VAR    = 48'h0000_0072_6176;
  localparam logic [STC_PREFIX_BITS-1:0] KW_FUNC   = 48'h0000_636e_7566;
  localparam logic [STC_PREFIX_BITS-1:0] KW_RETURN = 48'h6e72_7574_6572;

  localparam logic [2:0] LEN_VAR    = 3'd3;
  localparam logic [2:0] LEN_FUNC   = 3'd4;
  localparam logic [2:0] LEN_RETURN = 3'd6;
  localparam logic [2:0] LEN_HELD   = 3'd6;
  localparam logic [2:0] LEN_LONG   = 3'd7;

  localparam logic [1:0] BOM_LEN = 2'd3;

  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  function automatic logic [7:0] bom_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'hef;
      2'd1:    b = 8'hbb;
      2'd2:    b = 8'hbf;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_under(input logic [7:0] c);
    return c == 8'h5f;
  endfunction

  // one-byte punctuation; KIND_EOF means the byte is not punctuation
  function automatic tok_kind_t punct_kind(input logic [7:0] c);
    tok_kind_t k;
    unique case (c)
      8'h2b:   k = KIND_PLUS;
      8'h3d:   k = KIND_EQUAL;
      8'h3b:   k = KIND_SEMI;
      8'h3a:   k = KIND_COLON;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7b:   k = KIND_LBRACE;
      8'h7d:   k = KIND_RBRACE;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic tok_kind_t word_kind(input logic [STC_PREFIX_BITS-1:0] p,
                                          input logic [2:0] len);
    tok_kind_t k;
    k = KIND_IDENT;
    if (len == LEN_VAR && p == KW_VAR) begin
      k = KIND_VAR;
    end else if (len == LEN_FUNC && p == KW_FUNC) begin
      k = KIND_FUNC;
    end else if (len == LEN_RETURN && p == KW_RETURN) begin
      k = KIND_RETURN;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stc_front.sv =====
// scanner front end: classifies each byte, keeps position state, builds token bundles
`default_nettype none

module stc_front
  import stc_pkg::*;
#(
  parameter int OFFSET_BITS = STC_OFFSET_BITS,
  parameter int LINE_BITS   = STC_LINE_BITS,
  localparam int TOK_W      = 4 + 2 * OFFSET_BITS + 2 * LINE_BITS,
  localparam int BUNDLE_W   = 2 + STC_MAX_TOKENS * TOK_W
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [7:0]          text_byte,
  input  wire logic                byte_present,
  input  wire logic                text_end,
  output logic                     bundle_push,
  output logic [BUNDLE_W-1:0]      bundle
);

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  scan_mode_t                 mode_r, mode_nxt;
  logic [1:0]                 bom_prog_r, bom_prog_nxt;
  logic                       bom_open_r, bom_open_nxt;
  logic [OFFSET_BITS-1:0]     pos_r, pos_nxt;
  logic [LINE_BITS-1:0]       line_r, line_nxt;
  logic [LINE_BITS-1:0]       col_r, col_nxt;
  logic [OFFSET_BITS-1:0]     pstart_r, pstart_nxt;
  logic [LINE_BITS-1:0]       pline_r, pline_nxt;
  logic [LINE_BITS-1:0]       pcol_r, pcol_nxt;
  logic [STC_PREFIX_BITS-1:0] prefix_r, prefix_nxt;
  logic [2:0]                 wlen_r, wlen_nxt;

  logic [TOK_W-1:0]           slot [STC_MAX_TOKENS];
  logic [1:0]                 count;
  logic                       done;
  tok_kind_t                  pk;

  function automatic logic [LINE_BITS-1:0] sat_add(input logic [LINE_BITS-1:0] v,
                                                   input logic [1:0] d);
    logic [LINE_BITS:0] s;
    s = {1'b0, v} + {{(LINE_BITS - 1){1'b0}}, d};
    return s[LINE_BITS] ? {LINE_BITS{1'b1}} : s[LINE_BITS-1:0];
  endfunction

  function automatic logic [TOK_W-1:0] make_tok(input tok_kind_t k,
                                                input logic [OFFSET_BITS-1:0] s,
                                                input logic [OFFSET_BITS-1:0] e,
                                                input logic [LINE_BITS-1:0] ln,
                                                input logic [LINE_BITS-1:0] cl);
    return {k, s, e, ln, cl};
  endfunction

  always_comb begin
    mode_nxt     = mode_r;
    bom_prog_nxt = bom_prog_r;
    bom_open_nxt = bom_open_r;
    pos_nxt      = pos_r;
    line_nxt     = line_r;
    col_nxt      = col_r;
    pstart_nxt   = pstart_r;
    pline_nxt    = pline_r;
    pcol_nxt     = pcol_r;
    prefix_nxt   = prefix_r;
    wlen_nxt     = wlen_r;
    count        = 2'd0;
    done         = 1'b0;
    pk           = KIND_EOF;
    for (int i = 0; i < STC_MAX_TOKENS; i++) begin
      slot[i] = '0;
    end

    if (byte_present) begin
      // byte-order mark window at the head of the text
      if (bom_open_nxt) begin
        if (bom_prog_nxt < BOM_LEN && text_byte == bom_byte(bom_prog_nxt)) begin
          bom_prog_nxt = bom_prog_nxt + 2'd1;
          if (bom_prog_nxt == BOM_LEN) begin
            bom_prog_nxt = 2'd0;
            bom_open_nxt = 1'b0;
          end
          pos_nxt = pos_nxt + OFFSET_BITS'(1);
          done    = 1'b1;
        end else begin
          col_nxt      = sat_add(col_nxt, bom_prog_nxt);
          bom_prog_nxt = 2'd0;
          bom_open_nxt = 1'b0;
        end
      end

      if (!done) begin
        col_nxt = sat_add(col_nxt, 2'd1);
        case (mode_nxt)
          MODE_IDENT: begin
            if (is_alpha(text_byte) || is_digit(text_byte) || is_under(text_byte)) begin
              if (wlen_nxt < LEN_HELD) begin
                prefix_nxt[{wlen_nxt, 3'b000} +: 8] =
                  prefix_nxt[{wlen_nxt, 3'b000} +: 8] | text_byte;
                wlen_nxt = wlen_nxt + 3'd1;
              end else begin
                wlen_nxt = LEN_LONG;
              end
              pos_nxt = pos_nxt + OFFSET_BITS'(1);
              done    = 1'b1;
            end else begin
              slot[count] = make_tok(word_kind(prefix_nxt, wlen_nxt), pstart_nxt,
                                     pos_nxt, pline_nxt, pcol_nxt);
              count    = count + 2'd1;
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_NUM: begin
            if (is_digit(text_byte)) begin
              pos_nxt = pos_nxt + OFFSET_BITS'(1);
              done    = 1'b1;
            end else begin
              slot[count] = make_tok(KIND_INT, pstart_nxt, pos_nxt, pline_nxt, pcol_nxt);
              count    = count + 2'd1;
              mode_nxt = MODE_IDLE;
            end
          end
          default: mode_nxt = MODE_IDLE;
        endcase
      end

      // byte handled as if idle
      if (!done) begin
        pk = punct_kind(text_byte);
        if (text_byte == CH_NEWLINE) begin
          line_nxt = sat_add(line_nxt, 2'd1);
          col_nxt  = '0;
        end else if (pk != KIND_EOF) begin
          slot[count] = make_tok(pk, pos_nxt, pos_nxt + OFFSET_BITS'(1), line_nxt, col_nxt);
          count = count + 2'd1;
        end else if (is_alpha(text_byte) || is_under(text_byte) || is_digit(text_byte)) begin
          mode_nxt   = is_digit(text_byte) ? MODE_NUM : MODE_IDENT;
          pstart_nxt = pos_nxt;
          pline_nxt  = line_nxt;
          pcol_nxt   = col_nxt;
          prefix_nxt = {{(STC_PREFIX_BITS - 8){1'b0}}, text_byte};
          wlen_nxt   = 3'd1;
        end
        pos_nxt = pos_nxt + OFFSET_BITS'(1);
      end
    end

    if (text_end) begin
      if (bom_open_nxt) begin
        col_nxt = sat_add(col_nxt, bom_prog_nxt);
      end
      if (mode_nxt == MODE_IDENT) begin
        slot[count] = make_tok(word_kind(prefix_nxt, wlen_nxt), pstart_nxt, pos_nxt,
                               pline_nxt, pcol_nxt);
        count = count + 2'd1;
      end else if (mode_nxt == MODE_NUM) begin
        slot[count] = make_tok(KIND_INT, pstart_nxt, pos_nxt, pline_nxt, pcol_nxt);
        count = count + 2'd1;
      end
      slot[count] = make_tok(KIND_EOF, pos_nxt, pos_nxt, line_nxt, col_nxt);
      count = count + 2'd1;
      // back to the reset state for the next text
      mode_nxt     = MODE_IDLE;
      bom_prog_nxt = 2'd0;
      bom_open_nxt = 1'b1;
      pos_nxt      = '0;
      line_nxt     = LINE_ONE;
      col_nxt      = '0;
      pstart_nxt   = '0;
      pline_nxt    = LINE_ONE;
      pcol_nxt     = '0;
      prefix_nxt   = '0;
      wlen_nxt     = 3'd0;
    end
  end

  assign bundle_push = accept && (count != 2'd0);
  assign bundle      = {count, slot[2], slot[1], slot[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      bom_prog_r <= 2'd0;
      bom_open_r <= 1'b1;
      pos_r      <= '0;
      line_r     <= LINE_ONE;
      col_r      <= '0;
      pstart_r   <= '0;
      pline_r    <= LINE_ONE;
      pcol_r     <= '0;
      prefix_r   <= '0;
      wlen_r     <= 3'd0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      bom_prog_r <= bom_prog_nxt;
      bom_open_r <= bom_open_nxt;
      pos_r      <= pos_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      pstart_r   <= pstart_nxt;
      pline_r    <= pline_nxt;
      pcol_r     <= pcol_nxt;
      prefix_r   <= prefix_nxt;
      wlen_r     <= wlen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stc_fifo.sv =====
// small queue of token bundles between the front end and the output side
`default_nettype none

module stc_fifo
  import stc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = STC_QUEUE_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wptr_r, wptr_nxt;
  logic [AW:0]      rptr_r, rptr_nxt;

  assign empty = (wptr_r == rptr_r);
  assign full  = (wptr_r[AW] != rptr_r[AW]) && (wptr_r[AW-1:0] == rptr_r[AW-1:0]);
  assign rdata = mem[rptr_r[AW-1:0]];

  assign wptr_nxt = wptr_r + (AW + 1)'(push && !full);
  assign rptr_nxt = rptr_r + (AW + 1)'(pop && !empty);

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr_r[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stc_back.sv =====
// output side: holds one bundle and hands out its tokens one per pop
`default_nettype none

module stc_back
  import stc_pkg::*;
#(
  parameter int OFFSET_BITS = STC_OFFSET_BITS,
  parameter int LINE_BITS   = STC_LINE_BITS,
  localparam int TOK_W      = 4 + 2 * OFFSET_BITS + 2 * LINE_BITS,
  localparam int BUNDLE_W   = 2 + STC_MAX_TOKENS * TOK_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  input  wire logic [BUNDLE_W-1:0]    q_data,
  output logic                        q_pop,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic [3:0]                  out_token_kind,
  output logic [OFFSET_BITS-1:0]      out_start_offset,
  output logic [OFFSET_BITS-1:0]      out_end_offset,
  output logic [LINE_BITS-1:0]        out_line_number,
  output logic [LINE_BITS-1:0]        out_column_number,
  output logic                        out_last_of_run
);

  logic                busy_r, busy_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic [BUNDLE_W-1:0] data_r;
  logic [1:0]          cnt;
  logic [TOK_W-1:0]    tok;
  logic                last;
  logic                taken;

  assign cnt   = data_r[BUNDLE_W-1 -: 2];
  assign tok   = data_r[idx_r * TOK_W +: TOK_W];
  assign last  = (idx_r == cnt - 2'd1);
  assign taken = busy_r && out_pop;
  assign q_pop = !q_empty && (!busy_r || (taken && last));

  assign out_empty         = !busy_r;
  assign out_last_of_run   = last;
  assign out_token_kind    = tok[TOK_W-1 -: 4];
  assign out_start_offset  = tok[2*LINE_BITS + 2*OFFSET_BITS - 1 -: OFFSET_BITS];
  assign out_end_offset    = tok[2*LINE_BITS + OFFSET_BITS - 1 -: OFFSET_BITS];
  assign out_line_number   = tok[2*LINE_BITS - 1 -: LINE_BITS];
  assign out_column_number = tok[LINE_BITS - 1 : 0];

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (taken) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/source_text_tokenizer.sv =====
// top level of the streaming source text tokenizer
//
//   channel   direction  handshake        payload
//   in_       input      in_push/in_full  text_byte, byte_present, text_end
//   out_      output     out_empty/out_pop token_kind, offsets, line, column, last_of_run
//
// one byte item is taken per cycle while the bundle queue has room; the front end
// classifies it in that same cycle and queues the zero to three tokens it causes
// the output side hands out one token per cycle while out_pop is high and tokens are
// waiting; the four-entry queue soaks up bursts
// reset (synchronous, active low) empties the queue and returns the scanner to
// the start of a text: line 1, column 0, offset 0, mark window open
// a stalled output only stops input once the queue is full
`default_nettype none

module source_text_tokenizer
  import stc_pkg::*;
#(
  parameter int OFFSET_BITS = STC_OFFSET_BITS,
  parameter int LINE_BITS   = STC_LINE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // byte items in
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire logic [7:0]             in_text_byte,
  input  wire logic                   in_byte_present,
  input  wire logic                   in_text_end,
  // token items out
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic [3:0]                  out_token_kind,
  output logic [OFFSET_BITS-1:0]      out_start_offset,
  output logic [OFFSET_BITS-1:0]      out_end_offset,
  output logic [LINE_BITS-1:0]        out_line_number,
  output logic [LINE_BITS-1:0]        out_column_number,
  output logic                        out_last_of_run
);

  localparam int TOK_W    = 4 + 2 * OFFSET_BITS + 2 * LINE_BITS;
  localparam int BUNDLE_W = 2 + STC_MAX_TOKENS * TOK_W;

  logic                accept;
  logic                bundle_push;
  logic [BUNDLE_W-1:0] bundle;
  logic                q_empty;
  logic                q_pop;
  logic [BUNDLE_W-1:0] q_data;

  // an item goes in whenever the queue has a free bundle slot
  assign accept = in_push && !in_full;

  // front end: mark skipping, class checks, counters and token building
  stc_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .text_byte    (in_text_byte),
    .byte_present (in_byte_present),
    .text_end     (in_text_end),
    .bundle_push  (bundle_push),
    .bundle       (bundle)
  );

  // decoupling queue; items that cause no token leave nothing here
  stc_fifo #(
    .WIDTH (BUNDLE_W),
    .DEPTH (STC_QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bundle_push),
    .wdata (bundle),
    .full  (in_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_data)
  );

  // output side: serialises each bundle onto the result ports
  stc_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_token_kind    (out_token_kind),
    .out_start_offset  (out_start_offset),
    .out_end_offset    (out_end_offset),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

`default_nettype wire
